@@ hdl/fqpi_pkg.sv @@
// Shared types and constants for the ordered queue with positional insert.
// No dependencies; imported by every module of the block.
package fqpi_pkg;

   localparam int DEPTH       = 16;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int POS_W       = 5;
   localparam int CMD_W       = 2;
   localparam int STAT_W      = 2;
   localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int REQ_TDATA_W = ((CMD_W + DATA_W + POS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((DATA_W + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQ  = 2'd0,
      CMD_DEQ  = 2'd1,
      CMD_INS  = 2'd2,
      CMD_SHOW = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_OOB   = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
   } item_type;

   // head of the command queue as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } cmdq_head_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_SHOW = 2'b10
   } back_state_type;

endpackage

@@ hdl/fqpi_front.sv @@
// Front end: accepts request beats, unpacks them and holds them in a
// two-slot command queue for the back end. Depends on fqpi_pkg.
module fqpi_front import fqpi_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output cmdq_head_type          head,
   input  logic                   head_pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;
   item_type   req_item;

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign pop        = head_pop && head.valid;

   always_comb begin
      req_item.cmd      = cmd_type'(req_tdata[CMD_W-1:0]);
      req_item.value    = req_tdata[CMD_W +: DATA_W];
      req_item.position = req_tdata[CMD_W + DATA_W +: POS_W];
   end

   assign head.valid = (fill_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

@@ hdl/fqpi_back.sv @@
// Back end: holds the queue entries and count, executes one command at a
// time and drives the result register. Depends on fqpi_pkg.
module fqpi_back import fqpi_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cmdq_head_type          head,
   output logic                   head_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [STAT_W-1:0]      rsp_tuser,
   output logic                   rsp_tlast
);

   logic signed [DATA_W-1:0] entry_ff [DEPTH];
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   back_state_type           state_ff, state_in;
   logic                     out_valid_ff, out_valid_in;
   logic signed [DATA_W-1:0] out_data_ff, out_data_in;
   status_type               out_stat_ff, out_stat_in;
   logic                     out_last_ff, out_last_in;

   logic                     out_free, issue, show_emit, show_last;
   logic                     full, empty;
   logic [CMP_W-1:0]         cnt_cmp, pos_cmp, ins_pos;
   logic                     do_push, do_pop, show_more;
   status_type               res_stat;
   logic signed [DATA_W-1:0] res_data;
   logic                     res_last;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign issue     = (state_ff == BK_IDLE) && head.valid && out_free;
   assign head_pop  = issue;
   assign show_emit = (state_ff == BK_SHOW) && out_free;
   assign show_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff);

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign cnt_cmp = CMP_W'(cnt_ff);
   assign pos_cmp = CMP_W'(head.item.position);

   // classify the head command against the current fill
   always_comb begin
      res_stat  = ST_OK;
      res_data  = '0;
      res_last  = 1'b1;
      do_push   = 1'b0;
      do_pop    = 1'b0;
      show_more = 1'b0;
      ins_pos   = cnt_cmp;
      case (head.item.cmd)
         CMD_ENQ: begin
            if (full) res_stat = ST_FULL;
            else      do_push  = 1'b1;
         end
         CMD_DEQ: begin
            if (empty) begin
               res_stat = ST_EMPTY;
            end else begin
               do_pop   = 1'b1;
               res_data = entry_ff[0];
            end
         end
         CMD_INS: begin
            if (pos_cmp > cnt_cmp) begin
               res_stat = ST_OOB;
            end else if (full) begin
               res_stat = ST_FULL;
            end else begin
               do_push = 1'b1;
               ins_pos = pos_cmp;
            end
         end
         CMD_SHOW: begin
            if (empty) begin
               res_stat = ST_EMPTY;
            end else begin
               res_data  = entry_ff[0];
               res_last  = (cnt_ff == CNT_W'(1));
               show_more = (cnt_ff != CNT_W'(1));
            end
         end
         default: res_stat = ST_OK;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_stat_in  = out_stat_ff;
      out_last_in  = out_last_ff;
      if (issue) begin
         out_valid_in = 1'b1;
         out_data_in  = res_data;
         out_stat_in  = res_stat;
         out_last_in  = res_last;
         if (do_push) cnt_in = cnt_ff + CNT_W'(1);
         if (do_pop)  cnt_in = cnt_ff - CNT_W'(1);
         if (show_more) begin
            state_in = BK_SHOW;
            idx_in   = IDX_W'(1);
         end
      end else if (show_emit) begin
         out_valid_in = 1'b1;
         out_data_in  = entry_ff[idx_ff];
         out_stat_in  = ST_OK;
         out_last_in  = show_last;
         idx_in       = idx_ff + IDX_W'(1);
         if (show_last) state_in = BK_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      out_stat_ff <= out_stat_in;
      out_last_ff <= out_last_in;
   end

   // entry cells: shift up from the insert point, or shift down on dequeue
   always_ff @(posedge clock) begin
      if (issue && do_push) begin
         if (ins_pos == '0) entry_ff[0] <= head.item.value;
         for (int i = 1; i < DEPTH; i++) begin
            if (CMP_W'(i) > ins_pos)       entry_ff[i] <= entry_ff[i-1];
            else if (CMP_W'(i) == ins_pos) entry_ff[i] <= head.item.value;
         end
      end else if (issue && do_pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            entry_ff[i] <= entry_ff[i+1];
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(out_data_ff);
   assign rsp_tuser  = out_stat_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   a_show_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SHOW) |-> (idx_ff != '0 && CNT_W'(idx_ff) < cnt_ff))
      else $error("display index outside the filled range");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (issue && do_push) |=> (cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("count did not grow on a successful add");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (issue && do_pop) |=> (cnt_ff == $past(cnt_ff) - CNT_W'(1)))
      else $error("count did not shrink on a successful dequeue");

   a_show_end: assert property (@(posedge clock) disable iff (reset)
      (show_emit && show_last) |=> (state_ff == BK_IDLE && out_last_ff))
      else $error("display did not end on its last entry");
`endif

endmodule

@@ hdl/fifo_queue_with_positional_insert.sv @@
// Ordered queue with positional insert: enqueue, dequeue, insert, display.
// A request beat is held in a front-end command queue slot, then its result is registered in the back end.
// Enqueue, dequeue and insert each give one result beat; display gives one beat per entry
// (one beat when empty), one entry per cycle from the cell row unless the result channel stalls.
// Reset (synchronous, active high) empties the queue and both channels.
// Top level; depends on fqpi_pkg, fqpi_front and fqpi_back.
module fifo_queue_with_positional_insert import fqpi_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // cmd[1:0], value[33:2], position[38:34], 0
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // data[31:0]
   output logic [STAT_W-1:0]      rsp_tuser,  // status[1:0]
   output logic                   rsp_tlast   // final beat for this request
);

   // front end decouples request beats from the executing back end
   cmdq_head_type head;
   logic          head_pop;

   fqpi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .head       (head),
      .head_pop   (head_pop)
   );

   // back end owns the entry cells, the count and the result register
   fqpi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
